>>> src/mec_pkg.sv
// Shared types and constants for the Mandelbrot escape counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package mec_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int COUNT_WIDTH = 8;

  localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 8'd240;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take a new point and clear the round count
    logic mul_en;   // register the three products of the current z
    logic upd_en;   // step z and count the round unless it escaped
    logic emit;     // move the round count into the result register
  } mec_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_limit; // round count has reached the limit
    logic escaped;  // |z|^2 from the registered products exceeds 4.0
    logic out_free; // result register is empty or is being taken
  } mec_status_t;

endpackage

>>> src/mec_datapath.sv
// Datapath of the Mandelbrot escape counter: point and z registers, the three
// product multipliers, the escape test, the round count and the result register.
// Depends on mec_pkg.
module mec_datapath #(
  parameter int FRACTION_BITS = 26
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  mec_pkg::mec_cmd_t                    cmd,
  output mec_pkg::mec_status_t                 status,
  input  logic                                 cfg_write_enable,
  input  logic [mec_pkg::COUNT_WIDTH-1:0]      cfg_write_data,
  input  logic signed [mec_pkg::DATA_WIDTH-1:0] c_real,
  input  logic signed [mec_pkg::DATA_WIDTH-1:0] c_imag,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [mec_pkg::COUNT_WIDTH-1:0]      iteration_count
);
  import mec_pkg::*;

  localparam int PROD_WIDTH = 2 * DATA_WIDTH;
  localparam int CMP_WIDTH  = DATA_WIDTH + 2;
  // The threshold of 4.0 may not fit in the data width, so compare two bits wider.
  localparam logic signed [CMP_WIDTH-1:0] FOUR =
    CMP_WIDTH'(4) <<< FRACTION_BITS;

  logic [COUNT_WIDTH-1:0] max_iterations;
  logic [COUNT_WIDTH-1:0] count;
  logic signed [DATA_WIDTH-1:0] cr, ci, zr, zi;
  logic [DATA_WIDTH-1:0] sq_r, sq_i, cross_ri;

  logic signed [PROD_WIDTH-1:0] prod_rr, prod_ii, prod_ri;
  logic [DATA_WIDTH-1:0] mag;
  logic signed [CMP_WIDTH-1:0] mag_wide;

  assign prod_rr = PROD_WIDTH'(zr) * PROD_WIDTH'(zr);
  assign prod_ii = PROD_WIDTH'(zi) * PROD_WIDTH'(zi);
  assign prod_ri = PROD_WIDTH'(zr) * PROD_WIDTH'(zi);

  assign mag      = sq_r + sq_i;
  assign mag_wide = CMP_WIDTH'(signed'(mag));

  assign status.escaped  = mag_wide > FOUR;
  assign status.at_limit = count == max_iterations;
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= LIMIT_RESET;
    end else if (cfg_write_enable) begin
      max_iterations <= cfg_write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cr    <= c_real;
      ci    <= c_imag;
      zr    <= c_real;
      zi    <= c_imag;
      count <= '0;
    end else if (cmd.upd_en) begin
      zr <= signed'(sq_r - sq_i + DATA_WIDTH'(cr));
      zi <= signed'({cross_ri[DATA_WIDTH-2:0], 1'b0} + DATA_WIDTH'(ci));
      if (!status.escaped) begin
        count <= count + COUNT_WIDTH'(1);
      end
    end
    if (cmd.mul_en) begin
      sq_r     <= prod_rr[FRACTION_BITS+DATA_WIDTH-1:FRACTION_BITS];
      sq_i     <= prod_ii[FRACTION_BITS+DATA_WIDTH-1:FRACTION_BITS];
      cross_ri <= prod_ri[FRACTION_BITS+DATA_WIDTH-1:FRACTION_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      iteration_count <= count;
    end
  end

endmodule

>>> src/mec_ctrl.sv
// Controller of the Mandelbrot escape counter: sequences load, product and
// update steps for each point and hands the count to the result register.
// Depends on mec_pkg.
module mec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  mec_pkg::mec_status_t status,
  output mec_pkg::mec_cmd_t    cmd
);
  import mec_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (status.at_limit) begin
          state_next = S_DONE;
        end else begin
          cmd.mul_en = 1'b1;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd_en = 1'b1;
        state_next = status.escaped ? S_DONE : S_MUL;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/mandelbrot_escape_counter_top.sv
// Top level of the Mandelbrot escape counter: joins controller and datapath.
// Depends on mec_pkg, mec_ctrl and mec_datapath.
//
// Each request on the input channel carries one point c in signed fixed point
// with FRACTION_BITS fraction bits (6.26 by default). Starting from z = c the
// block repeats z = z*z + c, keeping bits FRACTION_BITS upwards of each 64-bit
// product and wrapping every sum to 32 bits, and stops at the first round in
// which |z|^2 taken before the update is greater than 4.0; that round is not
// counted. The result request carries the number of completed rounds, which is
// max_iterations when the point never escapes. max_iterations resets to 240.
// The user must write it through cfg_write_enable and cfg_write_data only
// while the block is idle; the block itself does not enforce this. One point
// is worked on at a time. In each round the block first forms and registers
// the three products zr*zr, zi*zi and zr*zi in parallel multipliers, then
// steps z and tests for escape. The block returns to idle and is ready for
// the next point once the result is loaded. The result sits in an output
// register, so the next point is accepted while an earlier result still
// waits to be taken.
module mandelbrot_escape_counter_top #(
  parameter int FRACTION_BITS = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write_enable,
  input  logic [mec_pkg::COUNT_WIDTH-1:0]       cfg_write_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [mec_pkg::DATA_WIDTH-1:0] c_real,
  input  logic signed [mec_pkg::DATA_WIDTH-1:0] c_imag,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [mec_pkg::COUNT_WIDTH-1:0]       iteration_count
);
  import mec_pkg::*;

  mec_cmd_t    cmd;
  mec_status_t status;

  // The controller only decides when each step happens; all arithmetic and
  // the escape test live in the datapath.
  mec_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mec_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .c_real           (c_real),
    .c_imag           (c_imag),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .iteration_count  (iteration_count)
  );

endmodule

>>> src/mec_checker.sv
// Port-level checks for the Mandelbrot escape counter and their binding.
// Depends on mec_pkg and mandelbrot_escape_counter_top.
module mec_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_write_enable,
  input logic [mec_pkg::COUNT_WIDTH-1:0]  cfg_write_data,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [mec_pkg::COUNT_WIDTH-1:0]  iteration_count
);
  import mec_pkg::*;

  logic [COUNT_WIDTH-1:0] limit_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      limit_seen <= LIMIT_RESET;
    end else if (cfg_write_enable) begin
      limit_seen <= cfg_write_data;
    end
  end

  // A held result keeps its value until taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(iteration_count))
    else $error("result changed or vanished while stalled");

  // Two points are never accepted back to back.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  // No count exceeds the configured limit.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> iteration_count <= limit_seen)
    else $error("iteration count above the limit");

  // Nothing is offered right after reset.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind mandelbrot_escape_counter_top mec_checker u_mec_checker (
  .clk              (clk),
  .rst              (rst),
  .cfg_write_enable (cfg_write_enable),
  .cfg_write_data   (cfg_write_data),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .iteration_count  (iteration_count)
);
